@@ design/rcs_pkg.sv @@
// Package for the ray-cast wall column shader: transaction types, register
// indexes, fixed-point constants, the cosine ROM builder and the texel clamp.
// No dependencies.
package rcs_pkg;

  localparam int MAX_ROWS     = 2048;
  localparam int MAX_TEX_SIZE = 1024;
  localparam int COS_DEPTH    = 1024;
  localparam int NUM_TEXTURES = 8;
  localparam int IDX_W        = $clog2(COS_DEPTH);

  // Angle index: |angle| * 1024 / 25736 equals |angle| * 128 / 3217.
  localparam logic [27:0] IDX_RECIP = 28'd170890834;  // floor(2^39 / 3217)
  localparam logic [11:0] IDX_DIV   = 12'd3217;

  localparam longint HALF_PI_Q28 = 64'sd421657428;
  localparam longint Q28_ONE     = 64'sd268435456;

  localparam logic [31:0] GREEN_COLOR = 32'h0000_FF00;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SCREEN_HEIGHT = 3'd0,
    CFG_WALL_SCALE    = 3'd1,
    CFG_CEILING_COLOR = 3'd2,
    CFG_FLOOR_COLOR   = 3'd3,
    CFG_TEX_WIDTH     = 3'd4,
    CFG_TEX_HEIGHT    = 3'd5
  } rcs_cfg_idx_t;

  // Pixel classes.
  typedef enum logic [1:0] {
    PC_CEILING  = 2'd0,
    PC_FLOOR    = 2'd1,
    PC_UNTEX    = 2'd2,
    PC_TEXTURED = 2'd3
  } rcs_class_t;

  typedef struct packed {
    logic [10:0]        row;
    logic [15:0]        wall_distance;
    logic signed [15:0] view_angle_offset;
    logic [1:0]         hit_face;
    logic [15:0]        hit_frac_x;
    logic [15:0]        hit_frac_y;
    logic               has_texture;
    logic [2:0]         texture_select;
    logic               last_in_column;
  } rcs_in_t;

  typedef struct packed {
    rcs_class_t  pixel_class;
    logic [31:0] color;
    logic [2:0]  texture_id;
    logic [9:0]  texel_x;
    logic [9:0]  texel_y;
    logic        column_done;
  } rcs_out_t;

  typedef logic [15:0] rcs_cos_rom_t [COS_DEPTH];

  // Cosine over a quarter turn in Q1.15, from a degree-12 Taylor series in
  // Q28 with truncating steps. Evaluated once at elaboration.
  function automatic rcs_cos_rom_t build_cos_rom();
    rcs_cos_rom_t rom;
    longint x;
    longint x2;
    longint c;
    longint q;
    for (int k = 0; k < COS_DEPTH; k++) begin
      x  = (longint'(k) * HALF_PI_Q28) / COS_DEPTH;
      x2 = (x * x) / Q28_ONE;
      c  = Q28_ONE;
      c  = Q28_ONE - ((x2 * c) / Q28_ONE) / 132;
      c  = Q28_ONE - ((x2 * c) / Q28_ONE) / 90;
      c  = Q28_ONE - ((x2 * c) / Q28_ONE) / 56;
      c  = Q28_ONE - ((x2 * c) / Q28_ONE) / 30;
      c  = Q28_ONE - ((x2 * c) / Q28_ONE) / 12;
      c  = Q28_ONE - ((x2 * c) / Q28_ONE) / 2;
      q  = (c >= 0) ? (c + 4096) / 8192 : 0;
      if (q < 1) q = 1;
      if (q > 32768) q = 32768;
      rom[k] = q[15:0];
    end
    return rom;
  endfunction

  // Clamp a texel coordinate to the texture size, capped at MAX_TEX_SIZE.
  function automatic logic [9:0] clamp_texel(logic [11:0] v, logic [10:0] size);
    logic [10:0] sz;
    logic [11:0] res;
    sz  = (size > 11'(MAX_TEX_SIZE)) ? 11'(MAX_TEX_SIZE) : size;
    res = v;
    if (sz == 11'd0) begin
      res = 12'd0;
    end else if (v > 12'(sz - 11'd1)) begin
      res = 12'(sz - 11'd1);
    end
    return res[9:0];
  endfunction

endpackage

@@ design/raycast_wall_column_shader_core.sv @@
// Top level of the ray-cast wall column shader: a 20-stage pipeline that
// classifies one pixel per clock. Depends on rcs_pkg.
//
//   port group | direction | handshake          | payload
//   in_        | input     | start high, busy low | in_data (rcs_in_t)
//   out_       | output    | out_valid strobe   | out_data (rcs_out_t)
//   cfg_       | input     | cfg_we             | cfg_index, cfg_wdata
//
// One pixel enters every clock; busy stays low. The texel_y quotient comes from
// the ten-stage restoring divider.
// Reset (synchronous, rst_n low) clears the valid bits and loads the register
// defaults. The receiver cannot stall, so the pipeline never holds.
module raycast_wall_column_shader_core
  import rcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rcs_in_t     in_data,
  output logic        out_valid,
  output rcs_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam rcs_cos_rom_t COS_ROM = build_cos_rom();
  localparam int DIV_STEPS = 10;

  // Configuration registers.
  logic [11:0] screen_height_r;
  logic [15:0] wall_scale_r;
  logic [31:0] ceiling_color_r;
  logic [31:0] floor_color_r;
  logic [10:0] tex_width_r;
  logic [10:0] tex_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= 12'd480;
      wall_scale_r    <= 16'd256;
      ceiling_color_r <= 32'd0;
      floor_color_r   <= 32'd0;
      tex_width_r     <= 11'd64;
      tex_height_r    <= 11'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[11:0];
        CFG_WALL_SCALE:    wall_scale_r    <= cfg_wdata[15:0];
        CFG_CEILING_COLOR: ceiling_color_r <= cfg_wdata;
        CFG_FLOOR_COLOR:   floor_color_r   <= cfg_wdata;
        CFG_TEX_WIDTH:     tex_width_r     <= cfg_wdata[10:0];
        CFG_TEX_HEIGHT:    tex_height_r    <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Derived configuration: clamped screen height and H*N.
  logic [11:0] h_c;
  logic [42:0] hn_r;
  assign h_c = (screen_height_r > 12'(MAX_ROWS)) ? 12'(MAX_ROWS) : screen_height_r;

  always_ff @(posedge clk) begin
    hn_r <= {28'(28'(h_c) * 28'(wall_scale_r)), 15'd0};
  end

  assign busy = 1'b0;

  // Stage 1: angle magnitude and reciprocal product for the ROM index.
  logic        v1_r;
  rcs_in_t     in1_r;
  logic [15:0] mag1_r;
  logic [43:0] prod1_r;
  logic [15:0] ang_u;
  logic [15:0] mag_nxt;

  assign ang_u   = in_data.view_angle_offset;
  assign mag_nxt = ang_u[15] ? (~ang_u + 16'd1) : ang_u;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    in1_r   <= in_data;
    mag1_r  <= mag_nxt;
    prod1_r <= 44'(mag_nxt) * 44'(IDX_RECIP);
  end

  // Stage 2: correct the estimated quotient and saturate the index.
  logic            v2_r;
  rcs_in_t         in2_r;
  logic [IDX_W-1:0] idx2_r;
  logic [11:0]     q0;
  logic [11:0]     qc;
  logic [23:0]     chk;
  logic [23:0]     mag128;
  logic [IDX_W-1:0] idx_nxt;

  always_comb begin
    q0      = prod1_r[43:32];
    chk     = 24'(q0 + 12'd1) * 24'(IDX_DIV);
    mag128  = {1'b0, mag1_r, 7'd0};
    qc      = (chk <= mag128) ? (q0 + 12'd1) : q0;
    idx_nxt = (qc >= 12'(COS_DEPTH)) ? IDX_W'(COS_DEPTH - 1) : qc[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    in2_r  <= in1_r;
    idx2_r <= idx_nxt;
  end

  // Stage 3: cosine ROM read.
  logic        v3_r;
  rcs_in_t     in3_r;
  logic [15:0] cos3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    in3_r  <= in2_r;
    cos3_r <= COS_ROM[idx2_r];
  end

  // Stage 4: D = distance * cos.
  logic        v4_r;
  rcs_in_t     in4_r;
  logic [31:0] d4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    in4_r <= in3_r;
    d4_r  <= 32'(in3_r.wall_distance) * 32'(cos3_r);
  end

  // Stage 5: 2row*D and H*D, plus the row side relative to the screen middle.
  logic        v5_r;
  rcs_in_t     in5_r;
  logic [43:0] a5_r;
  logic [43:0] b5_r;
  logic        gt5_r;
  logic        lt5_r;
  logic [11:0] two_row;

  assign two_row = {in4_r.row, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    in5_r <= in4_r;
    a5_r  <= 44'(two_row) * 44'(d4_r);
    b5_r  <= 44'(h_c) * 44'(d4_r);
    gt5_r <= h_c > two_row;
    lt5_r <= two_row > h_c;
  end

  // Stage 6: classify, start the texel_y numerator and the texel_x product.
  logic        v6_r;
  rcs_out_t    it6_r;
  logic [44:0] pos6_r;
  logic [43:0] b6_r;
  logic [27:0] txp6_r;
  logic [43:0] diff;
  logic        is_ceil;
  logic        is_floor;
  logic        is_tex;
  logic [16:0] rx;
  rcs_out_t    it6_nxt;

  always_comb begin
    diff     = gt5_r ? (b5_r - a5_r) : (a5_r - b5_r);
    is_ceil  = gt5_r && (diff > 44'(hn_r));
    is_floor = lt5_r && (diff > 44'(hn_r));
    is_tex   = in5_r.has_texture &&
               ({1'b0, in5_r.texture_select} < 4'(NUM_TEXTURES));
    unique case (in5_r.hit_face)
      2'd0:    rx = {1'b0, in5_r.hit_frac_x};
      2'd1:    rx = 17'h10000 - 17'(in5_r.hit_frac_x);
      2'd2:    rx = 17'h10000 - 17'(in5_r.hit_frac_y);
      default: rx = {1'b0, in5_r.hit_frac_y};
    endcase
    it6_nxt             = '0;
    it6_nxt.column_done = in5_r.last_in_column;
    priority if (is_ceil) begin
      it6_nxt.pixel_class = PC_CEILING;
      it6_nxt.color       = ceiling_color_r;
    end else if (is_floor) begin
      it6_nxt.pixel_class = PC_FLOOR;
      it6_nxt.color       = floor_color_r;
    end else if (!is_tex) begin
      it6_nxt.pixel_class = PC_UNTEX;
      it6_nxt.color       = GREEN_COLOR;
    end else begin
      it6_nxt.pixel_class = PC_TEXTURED;
      it6_nxt.texture_id  = in5_r.texture_select;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
    it6_r  <= it6_nxt;
    pos6_r <= 45'(a5_r) + 45'(hn_r);
    b6_r   <= b5_r;
    txp6_r <= 28'(rx) * 28'(tex_width_r);
  end

  // Stage 7: numerator and clamped texel_x.
  logic        v7_r;
  rcs_out_t    it7_r;
  logic [44:0] num7_r;
  rcs_out_t    it7_nxt;

  always_comb begin
    it7_nxt = it6_r;
    if (it6_r.pixel_class == PC_TEXTURED) begin
      it7_nxt.texel_x = clamp_texel(txp6_r[27:16], tex_width_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
    it7_r  <= it7_nxt;
    num7_r <= (pos6_r > 45'(b6_r)) ? (pos6_r - 45'(b6_r)) : 45'd0;
  end

  // Stage 8: dividend tex_height * numerator.
  logic        v8_r;
  rcs_out_t    it8_r;
  logic [55:0] x8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else        v8_r <= v7_r;
    it8_r <= it7_r;
    x8_r  <= 56'(tex_height_r) * 56'(num7_r);
  end

  // Stage 9 feeds the divider: saturation and zero-divisor flags.
  logic        dv_r   [DIV_STEPS+1];
  rcs_out_t    dit_r  [DIV_STEPS+1];
  logic [55:0] rem_r  [DIV_STEPS+1];
  logic [9:0]  q_r    [DIV_STEPS+1];
  logic        ovf_r  [DIV_STEPS+1];
  logic        zero_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= v8_r;
    dit_r[0]  <= it8_r;
    rem_r[0]  <= x8_r;
    q_r[0]    <= 10'd0;
    ovf_r[0]  <= x8_r >= (56'(hn_r) << 11);
    zero_r[0] <= (hn_r == 43'd0);
  end

  // Restoring divider by 2*H*N, one quotient bit per stage, MSB first.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic [55:0] sub;
    logic        take;

    assign sub  = 56'(hn_r) << (K + 1);
    assign take = rem_r[j] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else        dv_r[j+1] <= dv_r[j];
      dit_r[j+1]  <= dit_r[j];
      rem_r[j+1]  <= take ? (rem_r[j] - sub) : rem_r[j];
      q_r[j+1]    <= q_r[j] | (take ? (10'd1 << K) : 10'd0);
      ovf_r[j+1]  <= ovf_r[j];
      zero_r[j+1] <= zero_r[j];
    end
  end

  // Output register: final texel_y and the result strobe.
  logic     out_valid_r;
  rcs_out_t out_data_r;
  rcs_out_t out_nxt;
  logic [9:0] ty_raw;

  always_comb begin
    priority if (zero_r[DIV_STEPS]) begin
      ty_raw = 10'd0;
    end else if (ovf_r[DIV_STEPS]) begin
      ty_raw = 10'h3FF;
    end else begin
      ty_raw = q_r[DIV_STEPS];
    end
    out_nxt = dit_r[DIV_STEPS];
    if (out_nxt.pixel_class == PC_TEXTURED) begin
      out_nxt.texel_y = clamp_texel(12'(ty_raw), tex_height_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_r[DIV_STEPS];
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Texture fields stay zero outside the textured class.
  a_untex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pixel_class != PC_TEXTURED) |->
      (out_data.texel_x == 10'd0) && (out_data.texel_y == 10'd0) &&
      (out_data.texture_id == 3'd0))
    else $error("texture fields nonzero on a non-textured pixel");

  // A textured pixel carries no color.
  a_tex_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pixel_class == PC_TEXTURED) |-> (out_data.color == 32'd0))
    else $error("textured pixel has a color");

  // The texture column stays inside the texture.
  a_tx_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pixel_class == PC_TEXTURED) && (tex_width_r != 11'd0) |->
      ({1'b0, out_data.texel_x} < tex_width_r))
    else $error("texel_x beyond texture width");

  // Results appear only behind a valid stage.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dv_r[DIV_STEPS]))
    else $error("result strobe without a pipeline item");
`endif

endmodule

@@ bench/raycast_wall_column_shader_checker.sv @@
// Checker for the ray-cast wall column shader: watches the input, result and
// register ports, predicts each pixel and compares the results in order.
// Depends on rcs_pkg.
module raycast_wall_column_shader_checker
  import rcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  rcs_in_t     in_data,
  input  logic        out_valid,
  input  rcs_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ANGLE_SPAN = 64'd25736;

  longint unsigned cos_q15 [COS_DEPTH];
  longint unsigned scr_h, wscale, ceil_rgb, floor_rgb, tw, th;
  rcs_out_t pixel_q [$];

  // Quarter-turn cosine in Q1.15 from a truncated Taylor series in Q28.
  initial begin
    longint ang_q28, sq, acc, qv;
    for (int k = 0; k < COS_DEPTH; k++) begin
      ang_q28 = (longint'(k) * HALF_PI_Q28) / COS_DEPTH;
      sq = (ang_q28 * ang_q28) / Q28_ONE;
      acc = Q28_ONE;
      for (int t = 6; t >= 1; t--) begin
        acc = Q28_ONE - ((sq * acc) / Q28_ONE) / ((2 * t) * (2 * t - 1));
      end
      qv = (acc >= 0) ? (acc + 4096) / 8192 : 0;
      if (qv < 1) qv = 1;
      if (qv > 32768) qv = 32768;
      cos_q15[k] = longint'(qv);
    end
  end

  function automatic logic [9:0] clamp_coord(longint unsigned v, longint unsigned size);
    longint unsigned sz;
    sz = (size > MAX_TEX_SIZE) ? MAX_TEX_SIZE : size;
    if (sz == 0) return 10'd0;
    if (v > sz - 1) v = sz - 1;
    return v[9:0];
  endfunction

  // Classifies one pixel against the current register copy.
  function automatic rcs_out_t shade_pixel(rcs_in_t p);
    rcs_out_t r;
    longint unsigned ang, mag, idx, d, num_n, hh, hn, tr, rx, pos, neg, num, den, ty;
    r = '0;
    ang = longint'(p.view_angle_offset) & 64'hFFFF;
    mag = ang[15] ? (64'h10000 - ang) : ang;
    idx = mag * COS_DEPTH / ANGLE_SPAN;
    if (idx >= COS_DEPTH) idx = COS_DEPTH - 1;
    d = longint'(p.wall_distance) * cos_q15[idx];
    num_n = wscale * 32768;
    hh = (scr_h > MAX_ROWS) ? MAX_ROWS : scr_h;
    hn = hh * num_n;
    tr = 2 * longint'(p.row);
    r.column_done = p.last_in_column;
    if (hh > tr && (hh - tr) * d > hn) begin
      r.pixel_class = PC_CEILING;
      r.color = ceil_rgb[31:0];
    end else if (tr > hh && (tr - hh) * d > hn) begin
      r.pixel_class = PC_FLOOR;
      r.color = floor_rgb[31:0];
    end else if (!p.has_texture || p.texture_select >= NUM_TEXTURES) begin
      r.pixel_class = PC_UNTEX;
      r.color = GREEN_COLOR;
    end else begin
      r.pixel_class = PC_TEXTURED;
      r.texture_id = p.texture_select;
      case (p.hit_face)
        2'd0: rx = p.hit_frac_x;
        2'd1: rx = 64'h10000 - p.hit_frac_x;
        2'd2: rx = 64'h10000 - p.hit_frac_y;
        default: rx = p.hit_frac_y;
      endcase
      r.texel_x = clamp_coord((rx * tw) >> 16, tw);
      pos = tr * d + hn;
      neg = hh * d;
      num = (pos > neg) ? pos - neg : 0;
      den = 2 * hn;
      ty = (den == 0) ? 0 : (th * num) / den;
      r.texel_y = clamp_coord(ty, th);
    end
    return r;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = pixel_q.size();

  // Register copy, predictions on accepted transactions, in-order comparison.
  always @(posedge clk) begin
    rcs_out_t want;
    if (!rst_n) begin
      scr_h = 480; wscale = 256; ceil_rgb = 0; floor_rgb = 0; tw = 64; th = 64;
      pixel_q.delete();
    end else begin
      if (out_valid) begin
        if (pixel_q.size() == 0) begin
          report("unexpected result", out_data, 0);
        end else begin
          want = pixel_q.pop_front();
          if (out_data.pixel_class !== want.pixel_class)
            report("pixel_class", out_data.pixel_class, want.pixel_class);
          if (out_data.color !== want.color) report("color", out_data.color, want.color);
          if (out_data.texture_id !== want.texture_id)
            report("texture_id", out_data.texture_id, want.texture_id);
          if (out_data.texel_x !== want.texel_x)
            report("texel_x", out_data.texel_x, want.texel_x);
          if (out_data.texel_y !== want.texel_y)
            report("texel_y", out_data.texel_y, want.texel_y);
          if (out_data.column_done !== want.column_done)
            report("column_done", out_data.column_done, want.column_done);
        end
      end
      if (start && !busy) pixel_q.push_back(shade_pixel(in_data));
      if (cfg_we) begin
        case (rcs_cfg_idx_t'(cfg_index))
          CFG_SCREEN_HEIGHT: scr_h = cfg_wdata[11:0];
          CFG_WALL_SCALE:    wscale = cfg_wdata[15:0];
          CFG_CEILING_COLOR: ceil_rgb = cfg_wdata;
          CFG_FLOOR_COLOR:   floor_rgb = cfg_wdata;
          CFG_TEX_WIDTH:     tw = cfg_wdata[10:0];
          CFG_TEX_HEIGHT:    th = cfg_wdata[10:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ bench/raycast_wall_column_shader_core_tb.sv @@
// Top of the shader testbench: clock, reset, register phases and pixel
// stimulus. Depends on rcs_pkg and raycast_wall_column_shader_checker.
module raycast_wall_column_shader_core_tb;
  import rcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  rcs_in_t     in_data;
  logic        out_valid;
  rcs_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          errors;
  int          pending;
  int          cycles;
  int          cur_h;
  bit          allow_gaps;

  raycast_wall_column_shader_core dut (.*);

  raycast_wall_column_shader_checker chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(rcs_cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(int h, int scale, logic [31:0] c_rgb, logic [31:0] f_rgb,
                          int w, int th);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_WALL_SCALE, scale);
    write_reg(CFG_CEILING_COLOR, c_rgb);
    write_reg(CFG_FLOOR_COLOR, f_rgb);
    write_reg(CFG_TEX_WIDTH, w);
    write_reg(CFG_TEX_HEIGHT, th);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_h = h;
  endtask

  // Presents one transaction, with an optional idle burst ahead of it.
  task automatic send_pixel(rcs_in_t p);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_fields(int r, int wdist, int ang, int face, int fx, int fy,
                             bit tex, int sel, bit last);
    rcs_in_t p;
    p.row = 11'(r);
    p.wall_distance = 16'(wdist);
    p.view_angle_offset = 16'(ang);
    p.hit_face = 2'(face);
    p.hit_frac_x = 16'(fx);
    p.hit_frac_y = 16'(fy);
    p.has_texture = tex;
    p.texture_select = 3'(sel);
    p.last_in_column = last;
    send_pixel(p);
  endtask

  // Random pixel, mostly rows in and near the screen and textured walls.
  function automatic rcs_in_t rand_pixel();
    rcs_in_t p;
    logic [95:0] rnd;
    int hlim;
    rnd = {$urandom, $urandom, $urandom};
    p = rnd[$bits(rcs_in_t)-1:0];
    hlim = (cur_h < 1) ? 1 : ((cur_h > 2047) ? 2047 : cur_h);
    if ($urandom_range(0, 9) < 8) p.row = 11'($urandom_range(0, hlim));
    case ($urandom_range(0, 3))
      0: p.wall_distance = 16'($urandom_range(1, 255));
      1: p.wall_distance = 16'($urandom_range(256, 4096));
      default: p.wall_distance = 16'($urandom_range(1, 65535));
    endcase
    if ($urandom_range(0, 9) < 8)
      p.view_angle_offset = 16'($urandom_range(0, 51472) - 25736);
    if ($urandom_range(0, 9) < 7) p.has_texture = 1'b1;
    return p;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_pixel(rand_pixel());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cur_h = 480;
    allow_gaps = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the default registers: rows at both ends, each face,
    // extreme distances and angles, untextured hits and texture selects 0 to 7.
    send_fields(0, 1, 0, 0, 0, 0, 1, 0, 0);
    send_fields(2047, 1, 0, 1, 65535, 65535, 1, 7, 1);
    send_fields(240, 65535, 0, 0, 0, 0, 1, 3, 0);
    send_fields(0, 65535, 0, 0, 0, 0, 1, 3, 0);
    send_fields(479, 65535, 0, 0, 0, 0, 1, 3, 1);
    send_fields(240, 256, 25736, 0, 32768, 0, 1, 1, 0);
    send_fields(240, 256, -25736, 1, 0, 0, 1, 2, 0);
    send_fields(240, 256, -32768, 2, 0, 0, 1, 4, 0);
    send_fields(240, 256, 32767, 3, 0, 65535, 1, 5, 0);
    send_fields(200, 300, 1000, 0, 65535, 0, 1, 6, 0);
    send_fields(200, 300, 1000, 1, 0, 0, 1, 6, 0);
    send_fields(200, 300, 1000, 2, 0, 0, 1, 6, 0);
    send_fields(200, 300, 1000, 3, 0, 32768, 1, 6, 0);
    send_fields(200, 300, 1000, 3, 0, 32768, 0, 6, 1);
    send_fields(100, 300, 0, 0, 1234, 4321, 1, 0, 0);
    send_fields(400, 300, 0, 0, 1234, 4321, 1, 0, 0);
    send_fields(1500, 2000, -12000, 2, 777, 888, 1, 7, 1);
    drain();

    // Register phases with random traffic, extremes among them.
    set_regs(1, 65535, 32'hFFFF_FFFF, 32'h0000_0001, 1, 1);
    random_phase(250);
    set_regs(2048, 1, $urandom, $urandom, 1024, 1024);
    random_phase(250);
    set_regs(4095, 40, $urandom, $urandom, 2047, 2047);
    random_phase(200);
    set_regs(0, 0, $urandom, $urandom, 0, 0);
    random_phase(150);
    set_regs($urandom_range(1, 2048), $urandom_range(1, 65535), $urandom, $urandom,
             $urandom_range(1, 1024), $urandom_range(1, 1024));
    random_phase(300);
    set_regs(200, 300, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 37, 100);
    random_phase(300);
    set_regs(480, 256, $urandom, $urandom, 64, 64);
    allow_gaps = 1'b0;
    random_phase(300);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ raycast_wall_column_shader_core.f @@
design/rcs_pkg.sv
design/raycast_wall_column_shader_core.sv
bench/raycast_wall_column_shader_checker.sv
bench/raycast_wall_column_shader_core_tb.sv
